// ===== src/brfs_pkg.sv =====
// Shared types and codes for the bounded recent-first descriptor stack.
// Used by brfs_ctrl, brfs_dpath and bounded_recent_first_stack.
package brfs_pkg;

    // Action codes carried by an input transfer
    localparam logic [2:0] ACT_ADD        = 3'd0;
    localparam logic [2:0] ACT_READ_IDX   = 3'd1;
    localparam logic [2:0] ACT_READ_TOP   = 3'd2;
    localparam logic [2:0] ACT_REMOVE_TOP = 3'd3;
    localparam logic [2:0] ACT_REMOVE_IDX = 3'd4;
    localparam logic [2:0] ACT_REPLACE    = 3'd5;
    localparam logic [2:0] ACT_CLEAR      = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_EVICT = 2'd3;

    localparam logic [4:0] LIMIT_RESET = 5'd16;

    // Which entry the shared read port selects
    typedef enum logic [1:0] {
        RD_POS,
        RD_TOP,
        RD_BOTTOM
    } t_rd_sel;

    // Update applied to the entry chain and the count
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_REPLACE,
        OP_EVICT
    } t_cell_op;

    typedef struct packed {
        logic     capture;    // hold the accepted descriptor
        logic     emit;       // launch one result
        logic [1:0] status;
        logic     last;
        logic     take_data;  // result carries the read-port descriptor
        t_rd_sel  rd_sel;
        t_cell_op cell_op;
        logic     use_held;   // new descriptor comes from the held copy
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_one;
        logic at_limit;  // count has reached the effective limit
        logic pos_ok;    // requested position is below the count
        logic len_zero;  // requested length is zero
    } t_stat;

endpackage

// ===== src/brfs_ctrl.sv =====
// Sequencer for the descriptor stack: decodes actions and steps through
// evictions and clears. Depends on brfs_pkg.
module brfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [2:0]       i_action,
    input  brfs_pkg::t_stat  i_stat,
    output brfs_pkg::t_cmd   o_cmd,
    output logic             busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVICT,
        S_CLEAR
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd.capture   = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.status    = brfs_pkg::ST_OK;
        o_cmd.last      = 1'b1;
        o_cmd.take_data = 1'b0;
        o_cmd.rd_sel    = brfs_pkg::RD_POS;
        o_cmd.cell_op   = brfs_pkg::OP_NONE;
        o_cmd.use_held  = 1'b0;
        n_state         = r_state;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.emit    = 1'b1;
                    unique case (i_action)
                        brfs_pkg::ACT_ADD: begin
                            if (i_stat.len_zero) begin
                                o_cmd.status = brfs_pkg::ST_ZERO;
                            end else if (i_stat.at_limit) begin
                                o_cmd.status    = brfs_pkg::ST_EVICT;
                                o_cmd.last      = 1'b0;
                                o_cmd.take_data = 1'b1;
                                o_cmd.rd_sel    = brfs_pkg::RD_BOTTOM;
                                o_cmd.cell_op   = brfs_pkg::OP_EVICT;
                                n_state         = S_EVICT;
                            end else begin
                                o_cmd.cell_op = brfs_pkg::OP_INSERT;
                            end
                        end
                        brfs_pkg::ACT_READ_IDX, brfs_pkg::ACT_READ_TOP: begin
                            if (i_action == brfs_pkg::ACT_READ_TOP) begin
                                o_cmd.rd_sel = brfs_pkg::RD_TOP;
                            end
                            if ((i_action == brfs_pkg::ACT_READ_TOP) ? !i_stat.cnt_zero
                                                                    : i_stat.pos_ok) begin
                                o_cmd.take_data = 1'b1;
                            end else begin
                                o_cmd.status = brfs_pkg::ST_BAD;
                            end
                        end
                        brfs_pkg::ACT_REMOVE_TOP, brfs_pkg::ACT_REMOVE_IDX: begin
                            if (i_action == brfs_pkg::ACT_REMOVE_TOP) begin
                                o_cmd.rd_sel = brfs_pkg::RD_TOP;
                            end
                            if ((i_action == brfs_pkg::ACT_REMOVE_TOP) ? !i_stat.cnt_zero
                                                                      : i_stat.pos_ok) begin
                                o_cmd.take_data = 1'b1;
                                o_cmd.cell_op   = brfs_pkg::OP_REMOVE;
                            end else begin
                                o_cmd.status = brfs_pkg::ST_BAD;
                            end
                        end
                        brfs_pkg::ACT_REPLACE: begin
                            if (i_stat.len_zero) begin
                                o_cmd.status = brfs_pkg::ST_ZERO;
                            end else if (!i_stat.pos_ok) begin
                                o_cmd.status = brfs_pkg::ST_BAD;
                            end else begin
                                o_cmd.take_data = 1'b1;
                                o_cmd.cell_op   = brfs_pkg::OP_REPLACE;
                            end
                        end
                        brfs_pkg::ACT_CLEAR: begin
                            if (!i_stat.cnt_zero) begin
                                o_cmd.status    = brfs_pkg::ST_EVICT;
                                o_cmd.last      = i_stat.cnt_one;
                                o_cmd.take_data = 1'b1;
                                o_cmd.rd_sel    = brfs_pkg::RD_TOP;
                                o_cmd.cell_op   = brfs_pkg::OP_REMOVE;
                                if (!i_stat.cnt_one) begin
                                    n_state = S_CLEAR;
                                end
                            end
                        end
                        default: begin
                            o_cmd.status = brfs_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            S_EVICT: begin
                // drop bottom entries until below the limit, then insert
                o_cmd.emit = 1'b1;
                if (i_stat.at_limit) begin
                    o_cmd.status    = brfs_pkg::ST_EVICT;
                    o_cmd.last      = 1'b0;
                    o_cmd.take_data = 1'b1;
                    o_cmd.rd_sel    = brfs_pkg::RD_BOTTOM;
                    o_cmd.cell_op   = brfs_pkg::OP_EVICT;
                end else begin
                    o_cmd.cell_op  = brfs_pkg::OP_INSERT;
                    o_cmd.use_held = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.emit      = 1'b1;
                o_cmd.status    = brfs_pkg::ST_EVICT;
                o_cmd.last      = i_stat.cnt_one;
                o_cmd.take_data = 1'b1;
                o_cmd.rd_sel    = brfs_pkg::RD_TOP;
                o_cmd.cell_op   = brfs_pkg::OP_REMOVE;
                if (i_stat.cnt_one) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== src/brfs_dpath.sv =====
// Datapath of the descriptor stack: shifting entry chain, count, limit
// register, shared read port and result registers. Depends on brfs_pkg.
module brfs_dpath #(
    parameter int DEPTH = 16,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  brfs_pkg::t_cmd   i_cmd,
    output brfs_pkg::t_stat  o_stat,
    input  logic [7:0]       i_position,
    input  logic [31:0]      i_buffer_handle,
    input  logic [31:0]      i_buffer_length,
    input  logic             i_cfg_valid,
    input  logic [4:0]       i_cfg_data,
    output logic             o_result_valid,
    output logic [1:0]       o_status,
    output logic [31:0]      o_handle_out,
    output logic [31:0]      o_length_out,
    output logic [CNT_W-1:0] o_entry_count,
    output logic             o_last
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [31:0]      r_handle [DEPTH];
    logic [31:0]      r_length [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [4:0]       r_limit;
    logic [31:0]      r_held_handle;
    logic [31:0]      r_held_length;
    logic             r_result_valid;
    logic [1:0]       r_status;
    logic [31:0]      r_handle_out;
    logic [31:0]      r_length_out;
    logic [CNT_W-1:0] r_entry_count;
    logic             r_last;

    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      rd_handle;
    logic [31:0]      rd_length;
    logic [31:0]      new_handle;
    logic [31:0]      new_length;
    logic [5:0]       eff_limit;

    // zero limit acts as one; anything at or above DEPTH saturates via count check
    assign eff_limit = (r_limit == 5'd0) ? 6'd1 : {1'b0, r_limit};

    assign o_stat.cnt_zero = (r_count == '0);
    assign o_stat.cnt_one  = (r_count == CNT_W'(1));
    assign o_stat.at_limit = (7'(r_count) >= 7'(DEPTH)) || (7'(r_count) >= 7'(eff_limit));
    assign o_stat.pos_ok   = (9'(i_position) < 9'(r_count));
    assign o_stat.len_zero = (i_buffer_length == 32'd0);

    always_comb begin
        case (i_cmd.rd_sel)
            brfs_pkg::RD_POS:    rd_addr = i_position[IDX_W-1:0];
            brfs_pkg::RD_TOP:    rd_addr = '0;
            brfs_pkg::RD_BOTTOM: rd_addr = IDX_W'(r_count - CNT_W'(1));
            default:             rd_addr = '0;
        endcase
    end

    assign rd_handle  = r_handle[rd_addr];
    assign rd_length  = r_length[rd_addr];
    assign new_handle = i_cmd.use_held ? r_held_handle : i_buffer_handle;
    assign new_length = i_cmd.use_held ? r_held_length : i_buffer_length;

    always_comb begin
        case (i_cmd.cell_op)
            brfs_pkg::OP_INSERT:                   n_count = r_count + CNT_W'(1);
            brfs_pkg::OP_REMOVE, brfs_pkg::OP_EVICT: n_count = r_count - CNT_W'(1);
            default:                               n_count = r_count;
        endcase
    end

    // entry chain: each cell takes its neighbor, the new descriptor, or holds
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            case (i_cmd.cell_op)
                brfs_pkg::OP_INSERT: begin
                    if (g == 0) begin
                        r_handle[g] <= new_handle;
                        r_length[g] <= new_length;
                    end else begin
                        r_handle[g] <= r_handle[(g == 0) ? 0 : g - 1];
                        r_length[g] <= r_length[(g == 0) ? 0 : g - 1];
                    end
                end
                brfs_pkg::OP_REMOVE: begin
                    if ((g < DEPTH - 1) && (IDX_W'(g) >= rd_addr)) begin
                        r_handle[g] <= r_handle[(g < DEPTH - 1) ? g + 1 : g];
                        r_length[g] <= r_length[(g < DEPTH - 1) ? g + 1 : g];
                    end
                end
                brfs_pkg::OP_REPLACE: begin
                    if (IDX_W'(g) == rd_addr) begin
                        r_handle[g] <= new_handle;
                        r_length[g] <= new_length;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_held_handle <= i_buffer_handle;
            r_held_length <= i_buffer_length;
        end
        if (i_cmd.emit) begin
            r_status      <= i_cmd.status;
            r_handle_out  <= i_cmd.take_data ? rd_handle : 32'd0;
            r_length_out  <= i_cmd.take_data ? rd_length : 32'd0;
            r_entry_count <= n_count;
            r_last        <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_limit        <= brfs_pkg::LIMIT_RESET;
            r_result_valid <= 1'b0;
        end else begin
            r_count        <= n_count;
            r_result_valid <= i_cmd.emit;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_status       = r_status;
    assign o_handle_out   = r_handle_out;
    assign o_length_out   = r_length_out;
    assign o_entry_count  = r_entry_count;
    assign o_last         = r_last;

endmodule

// ===== src/bounded_recent_first_stack.sv =====
// Top level of the bounded recent-first descriptor stack.
// Instantiates brfs_ctrl and brfs_dpath; depends on brfs_pkg.
//
// Usage: drive start with an action while busy is low; the command is taken
// at that clock edge and its first result appears in the next cycle on the
// o_* result ports, marked by o_result_valid for exactly one cycle. The
// receiver cannot stall, so capture every strobed result; o_last marks the
// final result of a command. Read, remove, replace, rejected commands, an
// add that needs no eviction and a clear of an empty or one-entry stack
// leave busy low, and a new command may follow in the next cycle. An add
// that must evict entries reports one evicted entry per cycle, bottom
// first, then inserts and reports that, with busy high until the insert;
// clear reports one entry per cycle from the top down, busy staying high
// until the last one. That per-entry cost comes from the single read port
// on the entry chain. The entry limit register is written through the cfg
// channel (always ready); write it only while no command is in progress. A
// zero limit acts as one, and a limit above DEPTH acts as DEPTH.
module bounded_recent_first_stack #(
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command transfer
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   i_action,
    input  logic [7:0]                   i_position,
    input  logic [31:0]                  i_buffer_handle,
    input  logic [31:0]                  i_buffer_length,
    // limit register write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [4:0]                   i_cfg_data,
    // result transfer
    output logic                         o_result_valid,
    output logic [1:0]                   o_status,
    output logic [31:0]                  o_handle_out,
    output logic [31:0]                  o_length_out,
    output logic [$clog2(DEPTH+1)-1:0]   o_entry_count,
    output logic                         o_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    brfs_pkg::t_cmd  cmd;
    brfs_pkg::t_stat stat;

    // limit writes never conflict with the datapath, so take them at once
    assign o_cfg_ready = 1'b1;

    brfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    brfs_dpath #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_position      (i_position),
        .i_buffer_handle (i_buffer_handle),
        .i_buffer_length (i_buffer_length),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_handle_out    (o_handle_out),
        .o_length_out    (o_length_out),
        .o_entry_count   (o_entry_count),
        .o_last          (o_last)
    );

endmodule
